// File: design/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Shared constants and types for the bencode stream tokenizer: phase codes,
// event and error codes, token characters and default sizes.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned BST_MAX_DEPTH   = 32;
  localparam int unsigned BST_LENGTH_BITS = 32;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_INT_SIGN = 3'd2,
    PH_INT_PART = 3'd3,
    PH_STR_LEN  = 3'd4,
    PH_STR_BODY = 3'd5
  } phase_e;

  localparam logic [3:0] EV_NONE  = 4'd0;
  localparam logic [3:0] EV_LIST  = 4'd1;
  localparam logic [3:0] EV_DICT  = 4'd2;
  localparam logic [3:0] EV_SBYTE = 4'd3;
  localparam logic [3:0] EV_EMPTY = 4'd4;
  localparam logic [3:0] EV_NULL  = 4'd5;
  localparam logic [3:0] EV_INT   = 4'd6;
  localparam logic [3:0] EV_CLOSE = 4'd7;
  localparam logic [3:0] EV_ERROR = 4'd8;

  localparam logic [2:0] ER_NONE   = 3'd0;
  localparam logic [2:0] ER_CHAR   = 3'd1;
  localparam logic [2:0] ER_END    = 3'd2;
  localparam logic [2:0] ER_DANGLE = 3'd3;
  localparam logic [2:0] ER_KEY    = 3'd4;
  localparam logic [2:0] ER_OVF    = 3'd5;

  localparam logic [7:0] CH_NULL  = 8'h6E; // n
  localparam logic [7:0] CH_INT   = 8'h69; // i
  localparam logic [7:0] CH_LIST  = 8'h6C; // l
  localparam logic [7:0] CH_DICT  = 8'h64; // d
  localparam logic [7:0] CH_END   = 8'h65; // e
  localparam logic [7:0] CH_COLON = 8'h3A; // :
  localparam logic [7:0] CH_MINUS = 8'h2D; // -
  localparam logic [7:0] CH_ZERO  = 8'h30; // 0
  localparam logic [7:0] CH_NINE  = 8'h39; // 9

  // one container level on the stack
  typedef struct packed {
    logic is_dict;
    logic wants_value;
  } level_t;

endpackage

// File: design/bst_byte_if.sv
// ----------------------------------------------------------------------------
// bst_byte_if
// Valid/ready channel carrying one byte of the bencode stream.
// ----------------------------------------------------------------------------
interface bst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: design/bst_token_if.sv
// ----------------------------------------------------------------------------
// bst_token_if
// Valid/ready channel carrying one tokenizer event per input byte.
// ----------------------------------------------------------------------------
interface bst_token_if;
  logic               valid;
  logic               ready;
  logic [3:0]         event_res;
  logic signed [63:0] int_value;
  logic [7:0]         data_byte;
  logic               string_last;
  logic               as_key;
  logic [5:0]         depth;
  logic               root_done;
  logic [2:0]         error_code;

  modport source (output valid, output event_res, output int_value, output data_byte,
                  output string_last, output as_key, output depth, output root_done,
                  output error_code, input ready);
  modport sink   (input valid, input event_res, input int_value, input data_byte,
                  input string_last, input as_key, input depth, input root_done,
                  input error_code, output ready);
endinterface

// File: design/bencode_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// bencode_stream_tokenizer
// Byte-at-a-time bencode tokenizer with null extension. Emits one event per
// byte, with key flag, nesting depth and top-level completion.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------------
//   in_i    | in  | in_byte
//   out_o   | out | event_res, int_value, data_byte, string_last, as_key,
//           |     | depth, root_done, error_code
//
// One byte per cycle while the output is not stalled: a byte is tokenized in
// the cycle it is taken and its event sits in the output register the next cycle.
// The top stack level lives in a register; the level below it is prefetched
// from the stack RAM with each byte taken, so push, pop and attach all complete as the byte is taken.
// A stalled output holds its event; a new byte is still taken in the cycle
// the held event leaves. Reset clears phase, accumulator and stack pointer;
// the stack RAM needs no clearing.
// ----------------------------------------------------------------------------
module bencode_stream_tokenizer #(
  parameter int unsigned MAX_DEPTH   = bst_pkg::BST_MAX_DEPTH,
  parameter int unsigned LENGTH_BITS = bst_pkg::BST_LENGTH_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bst_byte_if.sink    in_i,
  bst_token_if.source out_o
);
  import bst_pkg::*;

  localparam int unsigned SP_W  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef struct packed {
    logic [2:0] err;
    logic       key;
    logic       root;
    level_t     lvl;
  } attach_t;

  // attach a finished value to the enclosing level
  function automatic attach_t attach_f(level_t lvl_in, logic has_level, logic is_string);
    attach_t r;
    r.err  = ER_NONE;
    r.key  = 1'b0;
    r.root = 1'b0;
    r.lvl  = lvl_in;
    if (!has_level) begin
      r.root = 1'b1;
    end else if (lvl_in.is_dict) begin
      if (!lvl_in.wants_value) begin
        if (!is_string) begin
          r.err = ER_KEY;
        end else begin
          r.key               = 1'b1;
          r.lvl.wants_value   = 1'b1;
        end
      end else begin
        r.lvl.wants_value = 1'b0;
      end
    end
    return r;
  endfunction

  // parse state
  phase_e           phase_q, phase_d;
  logic [63:0]      acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [SP_W-1:0]  sp_q, sp_d;
  level_t           top_q, top_d;
  level_t           below_q;

  // stack RAM holds every level under the top one
  level_t           stack_mem [MAX_DEPTH];
  logic             wr_en;
  logic [SP_W-1:0]  wr_ptr, rd_ptr;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  // result register
  logic               out_valid_q;
  logic [3:0]         ev_q, ev_d;
  logic signed [63:0] ival_q, ival_d;
  logic [7:0]         dbyte_q, dbyte_d;
  logic               last_q, last_d;
  logic               key_q, key_d;
  logic               root_q, root_d;
  logic [2:0]         err_q, err_d;
  logic [SP_W+5:0]    depth_ext;

  logic        in_fire;
  logic [7:0]  b;
  logic        is_digit;
  logic [3:0]  dval;
  logic [67:0] mul10;
  logic        len_ovf;
  logic        sp_nz, sp_full;
  attach_t     att_val, att_str, att_close;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_fire    = in_i.valid & in_i.ready;

  assign b        = in_i.in_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval     = is_digit ? b[3:0] : 4'd0;
  assign mul10    = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {64'd0, dval};
  assign len_ovf  = |mul10[67:LENGTH_BITS];

  assign sp_nz   = (sp_q != '0);
  assign sp_full = (sp_q >= SP_W'(MAX_DEPTH));

  assign att_val   = attach_f(top_q, sp_nz, 1'b0);
  assign att_str   = attach_f(top_q, sp_nz, 1'b1);
  assign att_close = attach_f(below_q, sp_q > SP_W'(1), 1'b0);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    sp_d    = sp_q;
    top_d   = top_q;
    wr_en   = 1'b0;
    ev_d    = EV_NONE;
    err_d   = ER_NONE;
    ival_d  = '0;
    dbyte_d = '0;
    last_d  = 1'b0;
    key_d   = 1'b0;
    root_d  = 1'b0;
    case (phase_q)
      PH_START: begin
        if (b == CH_NULL) begin
          ev_d   = EV_NULL;
          err_d  = att_val.err;
          key_d  = att_val.key;
          root_d = att_val.root;
          top_d  = att_val.lvl;
        end else if (b == CH_INT) begin
          acc_d   = '0;
          neg_d   = 1'b0;
          phase_d = PH_INT_SIGN;
        end else if (b == CH_LIST || b == CH_DICT) begin
          ev_d = (b == CH_LIST) ? EV_LIST : EV_DICT;
          if (sp_full) begin
            err_d = ER_OVF;
          end else begin
            wr_en             = sp_nz;
            top_d.is_dict     = (b == CH_DICT);
            top_d.wants_value = 1'b0;
            sp_d              = sp_q + 1'b1;
          end
        end else if (b == CH_END) begin
          if (!sp_nz) begin
            err_d = ER_END;
          end else if (top_q.is_dict && top_q.wants_value) begin
            err_d = ER_DANGLE;
          end else begin
            sp_d   = sp_q - 1'b1;
            ev_d   = EV_CLOSE;
            err_d  = att_close.err;
            key_d  = att_close.key;
            root_d = att_close.root;
            top_d  = att_close.lvl;
          end
        end else if (is_digit) begin
          acc_d   = {60'd0, dval};
          phase_d = PH_STR_LEN;
        end else begin
          err_d = ER_CHAR;
        end
      end
      PH_INT_SIGN: begin
        if (b == CH_MINUS) begin
          neg_d   = 1'b1;
          phase_d = PH_INT_PART;
        end else if (is_digit) begin
          acc_d   = {60'd0, dval};
          phase_d = PH_INT_PART;
        end else begin
          err_d = ER_CHAR;
        end
      end
      PH_INT_PART: begin
        if (is_digit) begin
          acc_d = mul10[63:0];
        end else if (b == CH_END) begin
          ev_d    = EV_INT;
          ival_d  = neg_q ? -$signed(acc_q) : $signed(acc_q);
          phase_d = PH_START;
          err_d   = att_val.err;
          key_d   = att_val.key;
          root_d  = att_val.root;
          top_d   = att_val.lvl;
        end else begin
          err_d = ER_CHAR;
        end
      end
      PH_STR_LEN: begin
        if (is_digit) begin
          if (len_ovf) begin
            err_d = ER_OVF;
          end else begin
            acc_d = mul10[63:0];
          end
        end else if (b == CH_COLON) begin
          if (acc_q == '0) begin
            ev_d    = EV_EMPTY;
            phase_d = PH_START;
            err_d   = att_str.err;
            key_d   = att_str.key;
            root_d  = att_str.root;
            top_d   = att_str.lvl;
          end else begin
            phase_d = PH_STR_BODY;
          end
        end else begin
          err_d = ER_CHAR;
        end
      end
      PH_STR_BODY: begin
        ev_d    = EV_SBYTE;
        dbyte_d = b;
        acc_d   = (acc_q == '0) ? '0 : acc_q - 64'd1;
        if (acc_q <= 64'd1) begin
          last_d  = 1'b1;
          phase_d = PH_START;
          err_d   = att_str.err;
          key_d   = att_str.key;
          root_d  = att_str.root;
          top_d   = att_str.lvl;
        end else begin
          key_d = sp_nz && top_q.is_dict && !top_q.wants_value;
        end
      end
      default: begin
        err_d = ER_CHAR;
      end
    endcase

    // any error drops the whole parse back to its reset state
    if (err_d != ER_NONE) begin
      phase_d = PH_START;
      acc_d   = '0;
      neg_d   = 1'b0;
      sp_d    = '0;
      wr_en   = 1'b0;
      ev_d    = EV_ERROR;
      ival_d  = '0;
      dbyte_d = '0;
      last_d  = 1'b0;
      key_d   = 1'b0;
      root_d  = 1'b0;
    end
  end

  // push writes the old top below the new one; prefetch the level under sp_d
  assign wr_ptr  = sp_q - 1'b1;
  assign wr_addr = wr_ptr[IDX_W-1:0];
  assign rd_ptr  = sp_d - SP_W'(2);
  assign rd_addr = rd_ptr[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire && wr_en) begin
      stack_mem[wr_addr] <= top_q;
    end
    if (in_fire) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        below_q <= top_q;
      end else begin
        below_q <= stack_mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        sp_q    <= sp_d;
      end
      out_valid_q <= in_fire | (out_valid_q & ~out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      top_q   <= top_d;
      ev_q    <= ev_d;
      ival_q  <= ival_d;
      dbyte_q <= dbyte_d;
      last_q  <= last_d;
      key_q   <= key_d;
      root_q  <= root_d;
      err_q   <= err_d;
    end
  end

  assign depth_ext = {6'd0, sp_q};

  assign out_o.valid       = out_valid_q;
  assign out_o.event_res   = ev_q;
  assign out_o.int_value   = ival_q;
  assign out_o.data_byte   = dbyte_q;
  assign out_o.string_last = last_q;
  assign out_o.as_key      = key_q;
  assign out_o.depth       = depth_ext[5:0];
  assign out_o.root_done   = root_q;
  assign out_o.error_code  = err_q;

endmodule

// File: bench/bencode_stream_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bencode_stream_tokenizer_tb
// Self-checking bench for the bencode tokenizer. A short directed stream hits
// every event and error kind. Random well-formed values with random content
// follow, mixed with truncated values, noise, deep nesting and over-long
// length prefixes. Each accepted byte is run through a local parser model and
// the expected token is compared field by field with the token that comes out.
// ----------------------------------------------------------------------------
module bencode_stream_tokenizer_tb;
  import bst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [3:0]         ev;
    logic signed [63:0] ival;
    logic [7:0]         data;
    logic               last;
    logic               key;
    logic [5:0]         depth;
    logic               root;
    logic [2:0]         err;
  } token_t;

  logic clk_i;
  logic rst_ni;

  bst_byte_if  in_if ();
  bst_token_if out_if ();

  bencode_stream_tokenizer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // parser model state
  phase_e      ph;
  logic [63:0] acc;
  logic        neg;
  level_t      lvl_stack [BST_MAX_DEPTH];
  int unsigned sp;
  token_t      tok;

  logic [7:0]  stream_q [$];
  token_t      expected_tokens [$];

  int unsigned bytes_queued;
  int unsigned bytes_fed;
  int unsigned tokens_checked;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned roots_seen;
  int unsigned deepest;
  int unsigned ev_hist [16];
  int unsigned err_hist [8];

  bit          byte_offered;
  bit          calm;
  bit          long_hold_done;
  int unsigned send_gap;
  int unsigned hold_left;
  token_t      seen_tok;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void clear_parser();
    ph  = PH_START;
    acc = '0;
    neg = 1'b0;
    sp  = 0;
    for (int i = 0; i < BST_MAX_DEPTH; i++) lvl_stack[i] = '0;
  endfunction

  // hang a finished value on the enclosing level
  function automatic logic [2:0] attach_value(input logic is_str);
    if (sp == 0) begin
      tok.root = 1'b1;
      return ER_NONE;
    end
    if (lvl_stack[sp-1].is_dict) begin
      if (!lvl_stack[sp-1].wants_value) begin
        if (!is_str) return ER_KEY;
        tok.key = 1'b1;
        lvl_stack[sp-1].wants_value = 1'b1;
      end else begin
        lvl_stack[sp-1].wants_value = 1'b0;
      end
    end
    return ER_NONE;
  endfunction

  function automatic token_t tokenize_byte(input logic [7:0] b);
    logic        digit;
    logic [63:0] d;
    logic [63:0] len_max;
    logic [2:0]  err;
    digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    d       = digit ? {56'd0, b - CH_ZERO} : 64'd0;
    len_max = (64'd1 << BST_LENGTH_BITS) - 64'd1;
    err     = ER_NONE;
    tok     = '0;
    tok.ev  = EV_NONE;
    case (ph)
      PH_START: begin
        if (b == CH_NULL) begin
          tok.ev = EV_NULL;
          err = attach_value(1'b0);
        end else if (b == CH_INT) begin
          acc = '0;
          neg = 1'b0;
          ph  = PH_INT_SIGN;
        end else if (b == CH_LIST || b == CH_DICT) begin
          tok.ev = (b == CH_LIST) ? EV_LIST : EV_DICT;
          if (sp >= BST_MAX_DEPTH) begin
            err = ER_OVF;
          end else begin
            lvl_stack[sp].is_dict     = (b == CH_DICT);
            lvl_stack[sp].wants_value = 1'b0;
            sp++;
          end
        end else if (b == CH_END) begin
          if (sp == 0) begin
            err = ER_END;
          end else begin
            sp--;
            if (lvl_stack[sp].is_dict && lvl_stack[sp].wants_value) begin
              err = ER_DANGLE;
            end else begin
              tok.ev = EV_CLOSE;
              err = attach_value(1'b0);
            end
          end
        end else if (digit) begin
          acc = d;
          ph  = PH_STR_LEN;
        end else begin
          err = ER_CHAR;
        end
      end
      PH_INT_SIGN: begin
        if (b == CH_MINUS) begin
          neg = 1'b1;
          ph  = PH_INT_PART;
        end else if (digit) begin
          acc = d;
          ph  = PH_INT_PART;
        end else begin
          err = ER_CHAR;
        end
      end
      PH_INT_PART: begin
        if (digit) begin
          acc = acc * 64'd10 + d;
        end else if (b == CH_END) begin
          tok.ev   = EV_INT;
          tok.ival = neg ? (64'd0 - acc) : acc;
          ph       = PH_START;
          err      = attach_value(1'b0);
        end else begin
          err = ER_CHAR;
        end
      end
      PH_STR_LEN: begin
        if (digit) begin
          if (acc > (len_max - d) / 64'd10) err = ER_OVF;
          else acc = acc * 64'd10 + d;
        end else if (b == CH_COLON) begin
          if (acc == 0) begin
            tok.ev = EV_EMPTY;
            ph     = PH_START;
            err    = attach_value(1'b1);
          end else begin
            ph = PH_STR_BODY;
          end
        end else begin
          err = ER_CHAR;
        end
      end
      PH_STR_BODY: begin
        tok.ev   = EV_SBYTE;
        tok.data = b;
        if (acc != 0) acc--;
        if (acc == 0) begin
          tok.last = 1'b1;
          ph       = PH_START;
          err      = attach_value(1'b1);
        end else begin
          tok.key = (sp != 0) && lvl_stack[sp-1].is_dict && !lvl_stack[sp-1].wants_value;
        end
      end
      default: err = ER_CHAR;
    endcase
    if (err != ER_NONE) begin
      clear_parser();
      tok     = '0;
      tok.ev  = EV_ERROR;
      tok.err = err;
    end
    tok.depth = 6'(sp);
    return tok;
  endfunction

  // --------------------------------------------------------------------------
  // Stream generation
  // --------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
    bytes_queued++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // never a digit or colon, so noise cannot build up a long length prefix
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic void gen_string();
    int unsigned n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 6);
    if (n < 10 && $urandom_range(0, 4) == 0) push_byte(CH_ZERO);
    push_text($sformatf("%0d", n));
    push_byte(CH_COLON);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_int();
    logic        neg_sign;
    int unsigned ndig;
    neg_sign = $urandom_range(0, 1);
    ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
    if (neg_sign && $urandom_range(0, 9) == 0) ndig = 0;
    push_byte(CH_INT);
    if (neg_sign) push_byte(CH_MINUS);
    repeat (ndig) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    push_byte(CH_END);
  endfunction

  function automatic void gen_value(input int unsigned budget);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (budget == 0 && r >= 60) r = r - 60;
    n = $urandom_range(0, 3);
    if (r < 25) begin
      gen_int();
    end else if (r < 50) begin
      gen_string();
    end else if (r < 60) begin
      push_byte(CH_NULL);
    end else if (r < 80) begin
      push_byte(CH_LIST);
      repeat (n) gen_value(budget - 1);
      push_byte(CH_END);
    end else begin
      push_byte(CH_DICT);
      repeat (n) begin
        gen_string();
        gen_value(budget - 1);
      end
      push_byte(CH_END);
    end
  endfunction

  // nest lists n deep; past the stack limit the last open overflows
  function automatic void push_deep(input int unsigned n);
    repeat (n) push_byte(CH_LIST);
    if (n <= BST_MAX_DEPTH) begin
      push_byte(CH_NULL);
      repeat (n) push_byte(CH_END);
    end
  endfunction

  function automatic void fill_random(input int unsigned upto);
    int unsigned r;
    int unsigned mark;
    int unsigned cut;
    while (bytes_queued < upto) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        gen_value($urandom_range(0, 3));
      end else if (r < 78) begin
        // value cut short, then a stray byte
        mark = stream_q.size();
        gen_value(2);
        cut = $urandom_range(1, stream_q.size() - mark);
        repeat (cut) void'(stream_q.pop_back());
        bytes_queued -= cut;
        push_byte(noise_byte());
      end else if (r < 86) begin
        repeat ($urandom_range(1, 3)) push_byte(noise_byte());
      end else if (r < 92) begin
        case ($urandom_range(0, 3))
          0: push_byte(CH_END);
          1: begin
            push_byte(CH_DICT);
            gen_string();
            push_byte(CH_END);
          end
          2: push_text("dne");
          default: push_text("dlee");
        endcase
      end else if (r < 96) begin
        push_deep($urandom_range(30, 33));
      end else begin
        push_text($sformatf("%0d", 64'd4294967290 + 64'($urandom_range(0, 12))));
        push_byte(noise_byte());
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    fail_cnt++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic cmp_field(input string name, input logic [63:0] g, input logic [63:0] w);
    if (g !== w)
      report_mismatch($sformatf("token %0d %s: got 0x%0h, want 0x%0h", tokens_checked,
                                name, g, w));
  endtask

  task automatic check_token(input token_t got);
    token_t want;
    tokens_checked++;
    ev_hist[got.ev]++;
    err_hist[got.err]++;
    if (got.root === 1'b1) roots_seen++;
    if (got.depth > deepest) deepest = got.depth;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("token with no byte behind it, event %0d", got.ev));
      return;
    end
    want = expected_tokens.pop_front();
    cmp_field("event_res", got.ev, want.ev);
    cmp_field("int_value", got.ival, want.ival);
    cmp_field("data_byte", got.data, want.data);
    cmp_field("string_last", got.last, want.last);
    cmp_field("as_key", got.key, want.key);
    cmp_field("depth", got.depth, want.depth);
    cmp_field("root_done", got.root, want.root);
    cmp_field("error_code", got.err, want.err);
  endtask

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (calm || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt % 400 == 0) calm = ($urandom_range(0, 3) == 0);
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d tokens outstanding", cycle_cnt,
               expected_tokens.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver, receiver, monitor
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && !byte_offered) begin
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        in_if.in_byte <= stream_q.pop_front();
        in_if.valid   <= 1'b1;
        byte_offered = 1'b1;
        send_gap     = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // one long hold-off while the stream keeps coming, so the block backs up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && tokens_checked >= 150) begin
        long_hold_done = 1'b1;
        hold_left      = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        hold_left = ($urandom_range(0, 4) == 0) ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        seen_tok = {out_if.event_res, out_if.int_value, out_if.data_byte, out_if.string_last,
                    out_if.as_key, out_if.depth, out_if.root_done, out_if.error_code};
        check_token(seen_tok);
      end
      // input transaction: predict its token
      if (in_if.valid && in_if.ready) begin
        expected_tokens.insert(expected_tokens.size(), tokenize_byte(in_if.in_byte));
        bytes_fed++;
        byte_offered = 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (stream_q.size() != 0 || byte_offered || expected_tokens.size() != 0)
      @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_parser();
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // byte extremes at top level, each event and each error kind but overflow
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("i-e");
    push_text("ie");
    push_text("0:");
    push_text("e");
    push_text("n");
    push_text("le");
    push_text("d1:ae");
    push_text("dne");
    push_text("dlee");
    wait_drained();

    // stack overflow, full depth, length limit, integer extremes and wrap
    push_deep(BST_MAX_DEPTH + 1);
    push_deep(BST_MAX_DEPTH);
    push_text("4294967295x");
    push_text("4294967296:");
    push_text("i-9223372036854775808e");
    push_text("i18446744073709551615e");
    push_text("i99999999999999999999999e");
    fill_random(320);
    // sender stops until every token is back
    wait_drained();
    fill_random(550);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d bytes, %0d tokens, %0d top-level values, deepest nesting %0d",
             bytes_fed, tokens_checked, roots_seen, deepest);
    $display("Events: list %0d dict %0d strbyte %0d empty %0d null %0d int %0d close %0d err %0d",
             ev_hist[EV_LIST], ev_hist[EV_DICT], ev_hist[EV_SBYTE], ev_hist[EV_EMPTY],
             ev_hist[EV_NULL], ev_hist[EV_INT], ev_hist[EV_CLOSE], ev_hist[EV_ERROR]);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
